### rtl/core/tsl_pkg.sv
// Package for the text stream line number filter.
// Holds widths, byte codes, register indexes, queue entry types and BCD helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;
  localparam int SLOT_COUNT    = NUMBER_DIGITS + 4;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [7:0] NEWLINE      = 8'h0A;
  localparam logic [7:0] TAB          = 8'h09;
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam logic [7:0] CONTROL_TOP  = 8'd31;
  localparam logic [7:0] DOLLAR       = 8'h24;
  localparam logic [7:0] CARET        = 8'h5E;
  localparam logic [7:0] SPACE        = 8'h20;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;

  localparam logic [BCD_W-1:0]  BCD_ONE     = BCD_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST  = '0;
  localparam logic [SLOT_W-1:0] SLOT_TAB    = SLOT_W'(NUMBER_DIGITS);
  localparam logic [SLOT_W-1:0] SLOT_DOLLAR = SLOT_W'(NUMBER_DIGITS + 1);
  localparam logic [SLOT_W-1:0] SLOT_CARET  = SLOT_W'(NUMBER_DIGITS + 2);
  localparam logic [SLOT_W-1:0] SLOT_FINAL  = SLOT_W'(NUMBER_DIGITS + 3);

  typedef enum logic [2:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } tsl_cfg_t;

  typedef struct packed {
    logic             number_en;
    logic [BCD_W-1:0] line_number;
    logic             dollar;
    logic             caret;
    logic [7:0]       final_byte;
  } tsl_entry_t;

  // Increment a BCD line number, saturating at all nines
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] val);
    logic [BCD_W-1:0] res;
    logic             carry;
    logic             all_nines;
    res       = val;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (val[4*i +: 4] != 4'd9) all_nines = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (val[4*i +: 4] == 4'd9) begin
          res[4*i +: 4] = 4'd0;
        end else begin
          res[4*i +: 4] = val[4*i +: 4] + 4'd1;
          carry         = 1'b0;
        end
      end
    end
    return all_nines ? val : res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tsl_stream_if.sv
// Stream interfaces for the input bytes and the output bytes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface tsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/tsl_cfg_regs.sv
// APB-style option registers of the filter.
// Depends on tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tsl_pkg::DATA_W-1:0] pwdata,
  output logic      [tsl_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tsl_pkg::tsl_cfg_t               cfg_o
);

  tsl_pkg::tsl_cfg_t cfg_q, cfg_d;
  tsl_pkg::reg_idx_e idx;
  logic              wr;
  logic              rd_bit;

  assign idx    = tsl_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d  = cfg_q;
    rd_bit = 1'b0;
    unique case (idx)
      tsl_pkg::REG_NUMBER_ALL: begin
        rd_bit = cfg_q.number_all;
        if (wr) cfg_d.number_all = pwdata[0];
      end
      tsl_pkg::REG_NUMBER_NONBLANK: begin
        rd_bit = cfg_q.number_nonblank;
        if (wr) cfg_d.number_nonblank = pwdata[0];
      end
      tsl_pkg::REG_SQUEEZE_BLANK: begin
        rd_bit = cfg_q.squeeze_blank;
        if (wr) cfg_d.squeeze_blank = pwdata[0];
      end
      tsl_pkg::REG_SHOW_ENDS: begin
        rd_bit = cfg_q.show_ends;
        if (wr) cfg_d.show_ends = pwdata[0];
      end
      tsl_pkg::REG_SHOW_TABS: begin
        rd_bit = cfg_q.show_tabs;
        if (wr) cfg_d.show_tabs = pwdata[0];
      end
      tsl_pkg::REG_SHOW_NONPRINTING: begin
        rd_bit = cfg_q.show_nonprinting;
        if (wr) cfg_d.show_nonprinting = pwdata[0];
      end
      default: begin
        rd_bit = 1'b0;
      end
    endcase
  end

  assign prdata = tsl_pkg::DATA_W'(rd_bit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tsl_front.sv
// Front end: accepts input bytes, tracks line state and the line number,
// and classifies each byte into a queue entry. Depends on tsl_pkg, tsl_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module tsl_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  tsl_pkg::tsl_cfg_t       cfg_i,
  tsl_in_if.sink                  in_s,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output tsl_pkg::tsl_entry_t     entry_o
);

  logic                      prev_nl_q, prev_nl_d;
  logic                      blank_q, blank_d;
  logic [tsl_pkg::BCD_W-1:0] bcd_q, bcd_d;

  logic                      accept;
  logic                      line_start;
  logic                      blank_cur;
  logic [tsl_pkg::BCD_W-1:0] lnum_cur;
  logic [7:0]                c;
  logic                      is_nl;
  logic                      drop;
  logic                      num_en;
  logic                      tab_hit;
  logic                      ctrl_hit;

  assign in_s.ready = ~q_full_i;
  assign accept     = in_s.valid & ~q_full_i;

  assign c          = in_s.in_byte;
  assign is_nl      = (c == tsl_pkg::NEWLINE);
  assign line_start = in_s.start_of_file | prev_nl_q;
  assign blank_cur  = in_s.start_of_file ? 1'b0 : blank_q;
  assign lnum_cur   = in_s.start_of_file ? tsl_pkg::BCD_ONE : bcd_q;

  assign drop     = cfg_i.squeeze_blank & line_start & is_nl & blank_cur;
  assign num_en   = line_start & ((cfg_i.number_all & ~cfg_i.number_nonblank) |
                                  (cfg_i.number_nonblank & ~is_nl));
  assign tab_hit  = cfg_i.show_tabs & (c == tsl_pkg::TAB);
  assign ctrl_hit = cfg_i.show_nonprinting & (c <= tsl_pkg::CONTROL_TOP) & ~is_nl &
                    (c != tsl_pkg::TAB);

  always_comb begin
    entry_o.number_en   = num_en;
    entry_o.line_number = lnum_cur;
    entry_o.dollar      = cfg_i.show_ends & is_nl;
    entry_o.caret       = tab_hit | ctrl_hit;
    entry_o.final_byte  = (tab_hit | ctrl_hit) ? 8'(c + tsl_pkg::CARET_OFFSET) : c;
  end

  assign push_o = accept & ~drop;

  always_comb begin
    prev_nl_d = prev_nl_q;
    blank_d   = blank_q;
    bcd_d     = bcd_q;
    if (accept) begin
      prev_nl_d = is_nl;
      blank_d   = drop ? blank_cur : (line_start & is_nl);
      bcd_d     = (num_en & ~drop) ? tsl_pkg::bcd_inc(lnum_cur) : lnum_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_nl_q <= 1'b1;
      blank_q   <= 1'b0;
      bcd_q     <= tsl_pkg::BCD_ONE;
    end else begin
      prev_nl_q <= prev_nl_d;
      blank_q   <= blank_d;
      bcd_q     <= bcd_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tsl_queue.sv
// Short entry queue between the front end and the back end.
// Depends on tsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  tsl_pkg::tsl_entry_t entry_i,
  input  wire logic           pop_i,
  output tsl_pkg::tsl_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);

  tsl_pkg::tsl_entry_t mem_q [tsl_pkg::QUEUE_DEPTH];

  logic [tsl_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tsl_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tsl_pkg::QPTR_W:0]   count_q, count_d;
  logic                       do_push;
  logic                       do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (tsl_pkg::QPTR_W+1)'(tsl_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push & ~do_pop) count_d = count_q + 1'b1;
    if (do_pop & ~do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tsl_back.sv
// Back end: walks the output slots of the head entry into the output register,
// one byte per cycle unless output stalls; depends on tsl_pkg, tsl_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module tsl_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tsl_pkg::tsl_entry_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  tsl_out_if.source           out_s
);

  logic                       mid_q, mid_d;
  logic [tsl_pkg::SLOT_W-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  logic                       load;
  logic [tsl_pkg::SLOT_W-1:0] cur;
  logic [tsl_pkg::SLOT_W-1:0] nxt;
  logic [tsl_pkg::SLOT_W-1:0] first_slot;
  logic [7:0]                 slot_byte;
  logic [7:0]                 digit_char [tsl_pkg::NUMBER_DIGITS];

  function automatic logic [tsl_pkg::SLOT_W-1:0] next_slot(
    input logic [tsl_pkg::SLOT_W-1:0] s,
    input logic                       dollar,
    input logic                       caret
  );
    logic [tsl_pkg::SLOT_W-1:0] n;
    n = s + 1'b1;
    if ((n == tsl_pkg::SLOT_DOLLAR) && !dollar) n = tsl_pkg::SLOT_CARET;
    if ((n == tsl_pkg::SLOT_CARET) && !caret) n = tsl_pkg::SLOT_FINAL;
    return n;
  endfunction

  assign first_slot = head_i.number_en ? tsl_pkg::SLOT_FIRST :
                      next_slot(tsl_pkg::SLOT_TAB, head_i.dollar, head_i.caret);
  assign cur  = mid_q ? step_q : first_slot;
  assign nxt  = next_slot(cur, head_i.dollar, head_i.caret);
  assign load = ~empty_i & (~out_valid_q | out_s.ready);

  // Space-pad leading zeros; the lowest digit always shows
  always_comb begin
    logic started;
    started = 1'b0;
    for (int i = tsl_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
      if ((head_i.line_number[4*i +: 4] != 4'd0) || (i == 0)) started = 1'b1;
      digit_char[i] = started ?
                      8'(tsl_pkg::DIGIT_ZERO + {4'h0, head_i.line_number[4*i +: 4]}) :
                      tsl_pkg::SPACE;
    end
  end

  always_comb begin
    slot_byte = head_i.final_byte;
    priority if (cur == tsl_pkg::SLOT_TAB) begin
      slot_byte = tsl_pkg::TAB;
    end else if (cur == tsl_pkg::SLOT_DOLLAR) begin
      slot_byte = tsl_pkg::DOLLAR;
    end else if (cur == tsl_pkg::SLOT_CARET) begin
      slot_byte = tsl_pkg::CARET;
    end else if (cur == tsl_pkg::SLOT_FINAL) begin
      slot_byte = head_i.final_byte;
    end else begin
      for (int i = 0; i < tsl_pkg::NUMBER_DIGITS; i++) begin
        if (cur == tsl_pkg::SLOT_W'(tsl_pkg::NUMBER_DIGITS - 1 - i)) slot_byte = digit_char[i];
      end
    end
  end

  always_comb begin
    mid_d       = mid_q;
    step_d      = step_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_s.ready ? 1'b0 : out_valid_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = slot_byte;
      out_last_d  = (cur == tsl_pkg::SLOT_FINAL);
      if (cur == tsl_pkg::SLOT_FINAL) begin
        mid_d = 1'b0;
        pop_o = 1'b1;
      end else begin
        mid_d  = 1'b1;
        step_d = nxt;
      end
    end
  end

  assign out_s.valid    = out_valid_q;
  assign out_s.out_byte = out_byte_q;
  assign out_s.last     = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mid_q       <= mid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

### rtl/core/text_stream_line_number_filter.sv
// Line numbering text filter: one input byte gives zero to nine output bytes.
// Throughput: one output byte per cycle while the output accepts it, set by
// the back end's slot walk; a four-entry queue lets the front end run ahead.
// Asynchronous active-low reset clears options, line state (line number one,
// at line start) and the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_stream_line_number_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  tsl_in_if.sink                          in_s,
  tsl_out_if.source                       out_s,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tsl_pkg::DATA_W-1:0] pwdata,
  output logic      [tsl_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  tsl_pkg::tsl_cfg_t   cfg;
  tsl_pkg::tsl_entry_t push_entry;
  tsl_pkg::tsl_entry_t head_entry;
  logic                push;
  logic                pop;
  logic                q_empty;
  logic                q_full;

  tsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_s     (in_s),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  tsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tsl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_s   (out_s)
  );

endmodule

`default_nettype wire

### tb/text_stream_line_number_filter_tb.sv
// Testbench for text_stream_line_number_filter: drives bytes and APB option writes,
// predicts the filtered byte stream and checks every output item in order.
// Depends on tsl_pkg, tsl_stream_if and the filter RTL.
`timescale 1ns / 1ps

import tsl_pkg::*;

typedef struct packed {
  logic [7:0] out_byte;
  logic       last;
} filtered_byte_t;

class filter_scoreboard;
  tsl_cfg_t         opts;
  logic [7:0]       prev_byte;
  logic             blank_seen;
  logic [BCD_W-1:0] line_bcd;
  filtered_byte_t   filtered_q[$];

  function new();
    opts       = '0;
    prev_byte  = NEWLINE;
    blank_seen = 1'b0;
    line_bcd   = BCD_ONE;
  endfunction

  function void push(logic [7:0] b, logic last);
    filtered_byte_t entry;
    entry.out_byte = b;
    entry.last     = last;
    filtered_q.push_back(entry);
  endfunction

  function int pending();
    return filtered_q.size();
  endfunction

  function void note_input(logic [7:0] in_byte, logic sof);
    logic [7:0] c;
    logic       at_start;
    logic       leading;
    logic       nines;
    logic       carry;
    logic [3:0] digit;
    c = in_byte;
    if (sof) begin
      line_bcd   = BCD_ONE;
      prev_byte  = NEWLINE;
      blank_seen = 1'b0;
    end
    at_start = (prev_byte == NEWLINE);
    // drop a repeated blank line
    if (opts.squeeze_blank && at_start && c == NEWLINE && blank_seen) return;
    blank_seen = at_start && (c == NEWLINE);
    if (at_start && ((opts.number_all && !opts.number_nonblank) ||
                     (opts.number_nonblank && c != NEWLINE))) begin
      leading = 1'b1;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
        digit = line_bcd[4*i +: 4];
        if (digit != 4'd0 || i == 0) leading = 1'b0;
        push(leading ? SPACE : DIGIT_ZERO + 8'(digit), 1'b0);
      end
      push(TAB, 1'b0);
      nines = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (line_bcd[4*i +: 4] != 4'd9) nines = 1'b0;
      end
      carry = !nines;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (line_bcd[4*i +: 4] == 4'd9) begin
            line_bcd[4*i +: 4] = 4'd0;
          end else begin
            line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    if (opts.show_ends && c == NEWLINE) push(DOLLAR, 1'b0);
    if (opts.show_tabs && c == TAB) begin
      push(CARET, 1'b0);
      c = TAB + CARET_OFFSET;
    end
    if (opts.show_nonprinting && c <= CONTROL_TOP && c != NEWLINE && c != TAB) begin
      push(CARET, 1'b0);
      c = c + CARET_OFFSET;
    end
    push(c, 1'b1);
    prev_byte = c;
  endfunction

  function int check(logic [7:0] got_byte, logic got_last, output string msg);
    filtered_byte_t want;
    if (filtered_q.size() == 0) begin
      msg = $sformatf("output item %02h last %0b with nothing pending", got_byte, got_last);
      return 1;
    end
    want = filtered_q.pop_front();
    if (got_byte !== want.out_byte || got_last !== want.last) begin
      msg = $sformatf("output item %02h last %0b, wanted %02h last %0b",
                      got_byte, got_last, want.out_byte, want.last);
      return 1;
    end
    return 0;
  endfunction
endclass

module text_stream_line_number_filter_tb;

  localparam int REG_COUNT     = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 3_000_000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              in_idle_on;
  logic              out_idle_on;
  int                errors;
  string             check_msg;
  filter_scoreboard  sb;

  tsl_in_if  in_if ();
  tsl_out_if out_if ();

  text_stream_line_number_filter u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_s    (in_if),
    .out_s   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_item(logic [7:0] b, logic sof);
    while (in_idle_on && $urandom_range(0, 99) < 22) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= b;
    in_if.start_of_file <= sof;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(b, sof);
  endtask

  // hold off the sender until every pending output item has been checked
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic bit0);
    logic [DATA_W-1:0] word;
    word    = $urandom();
    word[0] = bit0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_options(tsl_cfg_t c);
    drain();
    apb_write(ADDR_W'(4 * REG_NUMBER_ALL), c.number_all);
    apb_write(ADDR_W'(4 * REG_NUMBER_NONBLANK), c.number_nonblank);
    apb_write(ADDR_W'(4 * REG_SQUEEZE_BLANK), c.squeeze_blank);
    apb_write(ADDR_W'(4 * REG_SHOW_ENDS), c.show_ends);
    apb_write(ADDR_W'(4 * REG_SHOW_TABS), c.show_tabs);
    apb_write(ADDR_W'(4 * REG_SHOW_NONPRINTING), c.show_nonprinting);
    // spare addresses: ignored
    apb_write(ADDR_W'(4 * REG_COUNT), 1'b1);
    apb_write(ADDR_W'(4 * (REG_COUNT + 1)), 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.opts = c;
  endtask

  task automatic run_text(int count);
    int         pick;
    logic [7:0] b;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      b = NEWLINE;
      else if (pick < 35) b = TAB;
      else if (pick < 45) b = 8'($urandom_range(0, 31));
      else if (pick < 85) b = 8'($urandom_range(32, 126));
      else                b = 8'($urandom_range(127, 255));
      send_item(b, $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (sb.check(out_if.out_byte, out_if.last, check_msg) != 0) report(check_msg);
      end
      out_if.ready <= out_idle_on ? ($urandom_range(0, 99) >= 22) : 1'b1;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb                  = new();
    errors              = 0;
    in_idle_on          = 1'b1;
    out_idle_on         = 1'b1;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.in_byte       <= '0;
    in_if.start_of_file <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // options at reset: plain pass-through
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE, 1'b0);

    set_options('1);
    send_item(8'h61, 1'b1);
    send_item(TAB, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(TAB, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(NEWLINE, 1'b0);

    set_options(tsl_cfg_t'{number_all: 1'b1, default: 1'b0});
    send_item(NEWLINE, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(NEWLINE, 1'b0);
    send_item(8'h71, 1'b1);

    set_options(tsl_cfg_t'{show_tabs: 1'b1, default: 1'b0});
    send_item(TAB, 1'b0);
    set_options(tsl_cfg_t'{show_nonprinting: 1'b1, default: 1'b0});
    send_item(TAB, 1'b0);
    send_item(8'h1B, 1'b0);

    // random text under a range of option settings
    set_options('0);
    run_text(10);
    set_options('1);
    run_text(8);
    drain();
    run_text(8);
    for (int p = 0; p < 3; p++) begin
      set_options(tsl_cfg_t'($urandom_range(0, 63)));
      run_text(6);
    end

    set_options(tsl_cfg_t'($urandom_range(0, 63)));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_text(20);

    // long run of numbered lines: carries into the tens digit
    set_options(tsl_cfg_t'{number_all: 1'b1, default: 1'b0});
    send_item(NEWLINE, 1'b1);
    repeat (11) send_item(NEWLINE, 1'b0);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_text(5);

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
